/* design/assert_macros.svh */
// Assertion macros used by the chunked blob receiver top level.
// Each check is clocked on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge.
`define CBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define CBR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked blob receiver package
// Shared codes, reset constants and the result word type.
// ----------------------------------------------------------------------------
package cbr_pkg;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RECV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_SKIP = 2'd3;

  localparam logic [1:0] FUNC_BYTE       = 2'd0;
  localparam logic [1:0] FUNC_CONNECT    = 2'd1;
  localparam logic [1:0] FUNC_DISCONNECT = 2'd2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'd1;

  localparam logic [31:0] MAGIC_RESET   = 32'h5652_504D;
  localparam logic [15:0] VERSION_RESET = 16'd1;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [3:0] IDX_MAX        = 4'd15;
  localparam logic [3:0] IDX_HDR_LAST   = 4'd13;
  localparam logic [3:0] IDX_MAGIC_LO   = 4'd2;
  localparam logic [3:0] IDX_VERSION_LO = 4'd6;
  localparam logic [3:0] IDX_LENGTH_LO  = 4'd8;
  localparam logic [3:0] IDX_CRC_LO     = 4'd10;

  typedef struct packed {
    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [12:0] payload_offset;
    logic        header_accepted;
    logic        transfer_done;
    logic        crc_ok;
    logic [13:0] bytes_received;
    logic [13:0] total_length;
  } result_t;

endpackage

/* design/cbr_crc8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 byte update
// Advances a reflected CRC-32 by one data byte in eight unrolled steps.
// ----------------------------------------------------------------------------
module cbr_crc8 (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, c[31:1]} ^ (cbr_pkg::CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule

/* design/cbr_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked blob receiver core
// Holds the transfer state and computes one result word for each input word.
// ----------------------------------------------------------------------------
module cbr_core #(
  parameter int unsigned MAX_BLOB_BYTES = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          func,
  input  logic [7:0]          data_byte,
  input  logic                last_of_packet,
  input  logic [31:0]         exp_magic,
  input  logic [15:0]         exp_version,
  output cbr_pkg::result_t    result
);

  localparam int unsigned OW = $clog2(MAX_BLOB_BYTES + 1);

  logic [1:0]    status_code, status_code_next;
  logic          header_seen, header_seen_next;
  logic          blob_complete, blob_complete_next;
  logic [3:0]    byte_index, byte_index_next;
  logic [7:0]    seq_low_byte, seq_low_byte_next;
  logic [1:0]    packet_kind, packet_kind_next;
  logic [31:0]   staged_magic, staged_magic_next;
  logic [15:0]   staged_version, staged_version_next;
  logic [15:0]   staged_length, staged_length_next;
  logic [31:0]   staged_crc, staged_crc_next;
  logic [OW-1:0] length_target, length_target_next;
  logic [31:0]   crc_target, crc_target_next;
  logic [OW-1:0] write_offset, write_offset_next;
  logic [15:0]   next_sequence, next_sequence_next;
  logic [31:0]   running_crc, running_crc_next;
  logic [31:0]   crc_upd;

  cbr_crc8 u_crc (
    .crc_in  (running_crc),
    .data    (data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    logic [15:0] seq;
    logic [31:0] wo_wide;
    logic [31:0] wo_next_wide;
    logic [31:0] lt_next_wide;
    logic        full;
    logic        hdr_bad;
    logic [1:0]  hsel;
    status_code_next    = status_code;
    header_seen_next    = header_seen;
    blob_complete_next  = blob_complete;
    byte_index_next     = byte_index;
    seq_low_byte_next   = seq_low_byte;
    packet_kind_next    = packet_kind;
    staged_magic_next   = staged_magic;
    staged_version_next = staged_version;
    staged_length_next  = staged_length;
    staged_crc_next     = staged_crc;
    length_target_next  = length_target;
    crc_target_next     = crc_target;
    write_offset_next   = write_offset;
    next_sequence_next  = next_sequence;
    running_crc_next    = running_crc;
    result              = '0;
    seq                 = {data_byte, seq_low_byte};
    wo_wide             = 32'(write_offset);
    full                = wo_wide >= 32'(MAX_BLOB_BYTES);
    hdr_bad             = 1'b0;
    hsel                = byte_index[1:0] - 2'd2;

    unique case (func)
      cbr_pkg::FUNC_CONNECT: begin
        status_code_next    = cbr_pkg::ST_RECV;
        header_seen_next    = 1'b0;
        blob_complete_next  = 1'b0;
        byte_index_next     = '0;
        seq_low_byte_next   = '0;
        packet_kind_next    = cbr_pkg::KIND_NONE;
        staged_magic_next   = '0;
        staged_version_next = '0;
        staged_length_next  = '0;
        staged_crc_next     = '0;
        length_target_next  = '0;
        crc_target_next     = '0;
        write_offset_next   = '0;
        next_sequence_next  = 16'd1;
        running_crc_next    = cbr_pkg::CRC_INIT;
      end
      cbr_pkg::FUNC_DISCONNECT: begin
        if (status_code == cbr_pkg::ST_RECV && !blob_complete) begin
          status_code_next = cbr_pkg::ST_ERR;
        end
        byte_index_next  = '0;
        packet_kind_next = cbr_pkg::KIND_NONE;
      end
      cbr_pkg::FUNC_BYTE: begin
        if (status_code == cbr_pkg::ST_RECV) begin
          if (byte_index == 4'd0) begin
            seq_low_byte_next = data_byte;
          end else if (byte_index == 4'd1) begin
            if (seq == 16'd0) begin
              packet_kind_next    = cbr_pkg::KIND_HDR;
              staged_magic_next   = '0;
              staged_version_next = '0;
              staged_length_next  = '0;
              staged_crc_next     = '0;
            end else if (!header_seen) begin
              packet_kind_next = cbr_pkg::KIND_SKIP;
            end else if (seq != next_sequence) begin
              status_code_next = cbr_pkg::ST_ERR;
              packet_kind_next = cbr_pkg::KIND_SKIP;
            end else begin
              packet_kind_next   = cbr_pkg::KIND_DATA;
              next_sequence_next = next_sequence + 16'd1;
            end
          end else if (packet_kind == cbr_pkg::KIND_HDR) begin
            if (byte_index < cbr_pkg::IDX_VERSION_LO) begin
              staged_magic_next[8*hsel +: 8] = data_byte;
            end else if (byte_index < cbr_pkg::IDX_LENGTH_LO) begin
              staged_version_next[8*byte_index[0] +: 8] = data_byte;
            end else if (byte_index < cbr_pkg::IDX_CRC_LO) begin
              staged_length_next[8*byte_index[0] +: 8] = data_byte;
            end else if (byte_index < cbr_pkg::IDX_CRC_LO + 4'd4) begin
              staged_crc_next[8*hsel +: 8] = data_byte;
            end
          end else if (packet_kind == cbr_pkg::KIND_DATA) begin
            if (full) begin
              status_code_next = cbr_pkg::ST_ERR;
              packet_kind_next = cbr_pkg::KIND_SKIP;
            end else begin
              result.payload_valid  = 1'b1;
              result.payload_byte   = data_byte;
              result.payload_offset = wo_wide[12:0];
              if (write_offset < length_target) begin
                running_crc_next = crc_upd;
              end
              write_offset_next = write_offset + OW'(1);
            end
          end

          if (last_of_packet && status_code_next == cbr_pkg::ST_RECV &&
              byte_index != 4'd0) begin
            if (packet_kind_next == cbr_pkg::KIND_HDR) begin
              hdr_bad = (byte_index < cbr_pkg::IDX_HDR_LAST) ||
                        (staged_magic_next != exp_magic) ||
                        (staged_version_next != exp_version) ||
                        (32'(staged_length_next) > 32'(MAX_BLOB_BYTES));
              if (hdr_bad) begin
                status_code_next = cbr_pkg::ST_ERR;
              end else begin
                length_target_next     = OW'(staged_length_next);
                crc_target_next        = staged_crc_next;
                write_offset_next      = '0;
                next_sequence_next     = 16'd1;
                header_seen_next       = 1'b1;
                running_crc_next       = cbr_pkg::CRC_INIT;
                result.header_accepted = 1'b1;
              end
            end else if (packet_kind_next == cbr_pkg::KIND_DATA &&
                         write_offset_next >= length_target_next) begin
              blob_complete_next   = 1'b1;
              result.transfer_done = 1'b1;
              result.crc_ok        = (~running_crc_next) == crc_target_next;
              status_code_next     = result.crc_ok ? cbr_pkg::ST_DONE : cbr_pkg::ST_ERR;
            end
          end
        end

        if (last_of_packet) begin
          byte_index_next  = '0;
          packet_kind_next = cbr_pkg::KIND_NONE;
        end else if (byte_index < cbr_pkg::IDX_MAX) begin
          byte_index_next = byte_index + 4'd1;
        end
      end
      default: begin
      end
    endcase

    wo_next_wide          = 32'(write_offset_next);
    lt_next_wide          = 32'(length_target_next);
    result.status         = status_code_next;
    result.bytes_received = wo_next_wide[13:0];
    result.total_length   = lt_next_wide[13:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_code    <= cbr_pkg::ST_IDLE;
      header_seen    <= 1'b0;
      blob_complete  <= 1'b0;
      byte_index     <= '0;
      seq_low_byte   <= '0;
      packet_kind    <= cbr_pkg::KIND_NONE;
      staged_magic   <= '0;
      staged_version <= '0;
      staged_length  <= '0;
      staged_crc     <= '0;
      length_target  <= '0;
      crc_target     <= '0;
      write_offset   <= '0;
      next_sequence  <= 16'd1;
      running_crc    <= cbr_pkg::CRC_INIT;
    end else if (step) begin
      status_code    <= status_code_next;
      header_seen    <= header_seen_next;
      blob_complete  <= blob_complete_next;
      byte_index     <= byte_index_next;
      seq_low_byte   <= seq_low_byte_next;
      packet_kind    <= packet_kind_next;
      staged_magic   <= staged_magic_next;
      staged_version <= staged_version_next;
      staged_length  <= staged_length_next;
      staged_crc     <= staged_crc_next;
      length_target  <= length_target_next;
      crc_target     <= crc_target_next;
      write_offset   <= write_offset_next;
      next_sequence  <= next_sequence_next;
      running_crc    <= running_crc_next;
    end
  end

endmodule

/* design/chunked_blob_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked blob receiver
// Reassembles a blob from notification packets received one byte per word.
// ----------------------------------------------------------------------------
// Usage: input words carry func, data_byte and last_of_packet and are taken
// when in_valid is high and in_stall is low. Every input word produces exactly
// one result word on the output channel, taken when out_valid is high and
// out_stall is low. Connect (func 1) restarts reception; packets then start
// with a little-endian sequence number, sequence 0 being the header.
// A result appears in the cycle after its word is taken. One word is taken
// per cycle unless stalled; the CRC update and the header compares settle
// within that cycle. The output register holds a result while the receiver
// stalls, and in_stall is raised only when that register is full and stalled,
// so a new word enters in the same cycle that the previous result leaves.
// Reset clears the transfer state to idle, empties the output register and
// loads the default magic and version. The configuration registers are
// written through cfg_write, cfg_index and cfg_data; the user must do so only
// while no word is in flight, since the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunked_blob_receiver #(
  parameter int unsigned MAX_BLOB_BYTES = 8192
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     func,
  input  logic [7:0]                     data_byte,
  input  logic                           last_of_packet,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic                           payload_valid,
  output logic [7:0]                     payload_byte,
  output logic [12:0]                    payload_offset,
  output logic                           header_accepted,
  output logic                           transfer_done,
  output logic                           crc_ok,
  output logic [13:0]                    bytes_received,
  output logic [13:0]                    total_length,
  input  logic                           cfg_write,
  input  logic [cbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic              accept;
  logic [31:0]       exp_magic;
  logic [15:0]       exp_version;
  cbr_pkg::result_t  step_result;
  cbr_pkg::result_t  out_reg;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_magic   <= cbr_pkg::MAGIC_RESET;
      exp_version <= cbr_pkg::VERSION_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbr_pkg::CFG_MAGIC:   exp_magic   <= cfg_data;
        cbr_pkg::CFG_VERSION: exp_version <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  cbr_core #(
    .MAX_BLOB_BYTES (MAX_BLOB_BYTES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .func           (func),
    .data_byte      (data_byte),
    .last_of_packet (last_of_packet),
    .exp_magic      (exp_magic),
    .exp_version    (exp_version),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= step_result;
    end
  end

  assign status          = out_reg.status;
  assign payload_valid   = out_reg.payload_valid;
  assign payload_byte    = out_reg.payload_byte;
  assign payload_offset  = out_reg.payload_offset;
  assign header_accepted = out_reg.header_accepted;
  assign transfer_done   = out_reg.transfer_done;
  assign crc_ok          = out_reg.crc_ok;
  assign bytes_received  = out_reg.bytes_received;
  assign total_length    = out_reg.total_length;

  `CBR_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "Accepted word produced no result")
  `CBR_ASSERT_IMPL(a_done_status, out_valid && transfer_done, (status == cbr_pkg::ST_DONE) == crc_ok, "Completion status disagrees with CRC check")
  `CBR_ASSERT_IMPL(a_header_restart, out_valid && header_accepted, bytes_received == 14'd0 && status == cbr_pkg::ST_RECV, "Accepted header did not restart reception")
  `CBR_ASSERT_IMPL(a_idle_payload, out_valid && !payload_valid, payload_byte == 8'd0 && payload_offset == 13'd0, "Payload fields not cleared without payload")

endmodule

/* test/tb_chunked_blob_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked blob receiver testbench
// Drives connect, disconnect and packet words into the receiver, predicts
// each result word from a behavioral copy of the reassembly state and checks
// every result field in order. Stimulus runs through a short directed part,
// then random blob transfers (clean and broken) under three idling patterns
// and three register settings, with a long receiver hold-off in the last one.
// ----------------------------------------------------------------------------
module tb_chunked_blob_receiver;

  localparam int BLOB_MAX = 8192;
  localparam int HDR_WORDS = 14;
  localparam int WORDS_PER_PHASE = 400;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] FUNC_UNDEFINED = 2'd3;

  typedef logic [7:0] octets_t[$];

  typedef struct {
    logic [1:0] func_code;
    logic [7:0] octet;
    logic       ends_packet;
  } word_t;

  typedef enum int {
    FLAW_NONE, FLAW_CRC, FLAW_GAP, FLAW_SHORT_HDR, FLAW_MAGIC, FLAW_VERSION,
    FLAW_LENGTH, FLAW_DISCONNECT, FLAW_RESTART, FLAW_EARLY_DATA, FLAW_RUNT,
    FLAW_OVERFLOW
  } flaw_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = cbr_pkg::FUNC_BYTE;
  logic [7:0]  data_byte = 8'h00;
  logic        last_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [12:0] payload_offset;
  logic        header_accepted;
  logic        transfer_done;
  logic        crc_ok;
  logic [13:0] bytes_received;
  logic [13:0] total_length;
  logic        cfg_write = 1'b0;
  logic [cbr_pkg::CFG_IDX_W-1:0] cfg_index = cbr_pkg::CFG_MAGIC;
  logic [31:0] cfg_data = 32'h0;

  word_t   outbound[$];
  cbr_pkg::result_t awaited[$];
  int unsigned words_queued = 0;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 77;
  int unsigned holdoff_left = 0;
  logic        holdoff_go = 1'b0;
  int unsigned quiet_cycles = 0;

  // Receiver state as the block should hold it.
  logic [31:0] magic_cfg;
  logic [15:0] version_cfg;
  logic [1:0]  link_state;
  logic        hdr_valid;
  logic        blob_done;
  logic [3:0]  pos_in_pkt;
  logic [7:0]  seq_lo;
  logic [1:0]  pkt_kind;
  logic [31:0] hdr_magic;
  logic [15:0] hdr_version;
  logic [15:0] hdr_length;
  logic [31:0] hdr_crc;
  logic [13:0] blob_len;
  logic [31:0] blob_crc;
  logic [13:0] wr_count;
  logic [15:0] seq_next;
  logic [31:0] crc_acc;

  chunked_blob_receiver #(.MAX_BLOB_BYTES(BLOB_MAX)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .data_byte(data_byte),
    .last_of_packet(last_of_packet),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .payload_valid(payload_valid),
    .payload_byte(payload_byte),
    .payload_offset(payload_offset),
    .header_accepted(header_accepted),
    .transfer_done(transfer_done),
    .crc_ok(crc_ok),
    .bytes_received(bytes_received),
    .total_length(total_length),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ cbr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_blob();
    hdr_valid = 1'b0;
    blob_done = 1'b0;
    pos_in_pkt = 4'd0;
    seq_lo = 8'h00;
    pkt_kind = cbr_pkg::KIND_NONE;
    hdr_magic = 32'h0;
    hdr_version = 16'h0;
    hdr_length = 16'h0;
    hdr_crc = 32'h0;
    blob_len = 14'd0;
    blob_crc = 32'h0;
    wr_count = 14'd0;
    seq_next = 16'd1;
    crc_acc = cbr_pkg::CRC_INIT;
  endfunction

  function automatic cbr_pkg::result_t receive_word(input logic [1:0] f, input logic [7:0] b,
                                                    input logic l);
    cbr_pkg::result_t r;
    logic [15:0] seq;
    logic [3:0] pos;
    int p;
    r = '0;
    if (f == cbr_pkg::FUNC_CONNECT) begin
      clear_blob();
      link_state = cbr_pkg::ST_RECV;
    end else if (f == cbr_pkg::FUNC_DISCONNECT) begin
      if (link_state == cbr_pkg::ST_RECV && !blob_done) begin
        link_state = cbr_pkg::ST_ERR;
      end
      pos_in_pkt = 4'd0;
      pkt_kind = cbr_pkg::KIND_NONE;
    end else if (f == cbr_pkg::FUNC_BYTE) begin
      pos = pos_in_pkt;
      if (link_state == cbr_pkg::ST_RECV) begin
        if (pos == 4'd0) begin
          seq_lo = b;
        end else if (pos == 4'd1) begin
          seq = {b, seq_lo};
          if (seq == 16'd0) begin
            pkt_kind = cbr_pkg::KIND_HDR;
            hdr_magic = 32'h0;
            hdr_version = 16'h0;
            hdr_length = 16'h0;
            hdr_crc = 32'h0;
          end else if (!hdr_valid) begin
            pkt_kind = cbr_pkg::KIND_SKIP;
          end else if (seq != seq_next) begin
            link_state = cbr_pkg::ST_ERR;
            pkt_kind = cbr_pkg::KIND_SKIP;
          end else begin
            pkt_kind = cbr_pkg::KIND_DATA;
            seq_next = seq_next + 16'd1;
          end
        end else if (pkt_kind == cbr_pkg::KIND_HDR) begin
          p = int'(pos) - 2;
          if (p < 4) begin
            hdr_magic[8*p +: 8] = b;
          end else if (p < 6) begin
            hdr_version[8*(p-4) +: 8] = b;
          end else if (p < 8) begin
            hdr_length[8*(p-6) +: 8] = b;
          end else if (p < 12) begin
            hdr_crc[8*(p-8) +: 8] = b;
          end
        end else if (pkt_kind == cbr_pkg::KIND_DATA) begin
          if (wr_count >= BLOB_MAX) begin
            link_state = cbr_pkg::ST_ERR;
            pkt_kind = cbr_pkg::KIND_SKIP;
          end else begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_offset = wr_count[12:0];
            if (wr_count < blob_len) begin
              crc_acc = crc_step(crc_acc, b);
            end
            wr_count = wr_count + 14'd1;
          end
        end
        if (l && link_state == cbr_pkg::ST_RECV && pos >= 4'd1) begin
          if (pkt_kind == cbr_pkg::KIND_HDR) begin
            if (int'(pos) + 1 < HDR_WORDS || hdr_magic != magic_cfg ||
                hdr_version != version_cfg || hdr_length > BLOB_MAX) begin
              link_state = cbr_pkg::ST_ERR;
            end else begin
              blob_len = hdr_length[13:0];
              blob_crc = hdr_crc;
              wr_count = 14'd0;
              seq_next = 16'd1;
              hdr_valid = 1'b1;
              crc_acc = cbr_pkg::CRC_INIT;
              r.header_accepted = 1'b1;
            end
          end else if (pkt_kind == cbr_pkg::KIND_DATA && wr_count >= blob_len) begin
            blob_done = 1'b1;
            r.transfer_done = 1'b1;
            r.crc_ok = (~crc_acc == blob_crc);
            link_state = r.crc_ok ? cbr_pkg::ST_DONE : cbr_pkg::ST_ERR;
          end
        end
      end
      if (l) begin
        pos_in_pkt = 4'd0;
        pkt_kind = cbr_pkg::KIND_NONE;
      end else if (pos_in_pkt < 4'd15) begin
        pos_in_pkt = pos_in_pkt + 4'd1;
      end
    end
    r.status = link_state;
    r.bytes_received = wr_count;
    r.total_length = blob_len;
    return r;
  endfunction

  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Sender: a new word is presented only once the previous one was taken.
  always @(posedge clk) begin
    word_t next_word;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited.push_back(receive_word(func, data_byte, last_of_packet));
      end
      if (!in_valid || !in_stall) begin
        if (outbound.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = outbound.pop_front();
          in_valid <= 1'b1;
          func <= next_word.func_code;
          data_byte <= next_word.octet;
          last_of_packet <= next_word.ends_packet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
    end else if (holdoff_go) begin
      holdoff_left <= HOLDOFF_CYCLES;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (holdoff_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cbr_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        flag_error("result word with no expected result pending");
      end else begin
        want = awaited.pop_front();
        check_field("status", status, want.status);
        check_field("payload_valid", payload_valid, want.payload_valid);
        check_field("payload_byte", payload_byte, want.payload_byte);
        check_field("payload_offset", payload_offset, want.payload_offset);
        check_field("header_accepted", header_accepted, want.header_accepted);
        check_field("transfer_done", transfer_done, want.transfer_done);
        check_field("crc_ok", crc_ok, want.crc_ok);
        check_field("bytes_received", bytes_received, want.bytes_received);
        check_field("total_length", total_length, want.total_length);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic [1:0] f, input logic [7:0] b, input logic l);
    outbound.push_back('{f, b, l});
    words_queued++;
  endtask

  task automatic queue_packet(input logic [15:0] seq, input octets_t body);
    queue_word(cbr_pkg::FUNC_BYTE, seq[7:0], 1'b0);
    queue_word(cbr_pkg::FUNC_BYTE, seq[15:8], body.size() == 0);
    foreach (body[i]) begin
      queue_word(cbr_pkg::FUNC_BYTE, body[i], i == body.size() - 1);
    end
  endtask

  function automatic octets_t header_body(input logic [31:0] magic,
                                          input logic [15:0] version,
                                          input logic [15:0] len,
                                          input logic [31:0] crc);
    octets_t body;
    logic [95:0] fields;
    fields = {crc, len, version, magic};
    for (int i = 0; i < 12; i++) begin
      body.push_back(fields[8*i +: 8]);
    end
    return body;
  endfunction

  task automatic send_blob(input int unsigned len, input int unsigned chunk_max,
                           input flaw_e flaw);
    octets_t blob;
    octets_t hdr;
    octets_t part;
    logic [31:0] crc;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] hlen;
    logic [15:0] seq;
    logic [15:0] bad_seq;
    int unsigned pos;
    int unsigned n;
    int unsigned extra;
    int unsigned cut_at;
    bit struck;
    bit strike;
    crc = cbr_pkg::CRC_INIT;
    extra = (flaw == FLAW_OVERFLOW) ? $urandom_range(1, 3) :
            (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
    for (int i = 0; i < len + extra; i++) begin
      blob.push_back(8'($urandom));
      if (i < len) begin
        crc = crc_step(crc, blob[i]);
      end
    end
    crc = ~crc;
    magic = magic_cfg;
    version = version_cfg;
    hlen = 16'(len);
    case (flaw)
      FLAW_CRC: crc = crc ^ (32'h1 << $urandom_range(31));
      FLAW_MAGIC: magic = magic ^ (32'h1 << $urandom_range(31));
      FLAW_VERSION: version = version ^ (16'h1 << $urandom_range(15));
      FLAW_LENGTH: hlen = 16'($urandom_range(BLOB_MAX + 1, 16'hFFFF));
      default: ;
    endcase
    hdr = header_body(magic, version, hlen, crc);
    if (flaw == FLAW_SHORT_HDR) begin
      n = $urandom_range(11);
      while (hdr.size() > n) void'(hdr.pop_back());
    end else if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 4)) hdr.push_back(8'($urandom));
    end

    queue_word(cbr_pkg::FUNC_CONNECT, 8'($urandom), 1'($urandom));
    if (flaw == FLAW_EARLY_DATA) begin
      queue_packet(16'($urandom_range(1, 16'hFFFF)), hdr);
    end
    queue_packet(16'h0000, hdr);

    seq = 16'd1;
    pos = 0;
    cut_at = $urandom_range(1, 3);
    struck = 1'b0;
    do begin
      strike = !struck && seq == cut_at;
      if (strike) begin
        struck = 1'b1;
      end
      if (strike && flaw == FLAW_DISCONNECT) begin
        queue_word(cbr_pkg::FUNC_BYTE, seq[7:0], 1'b0);
        queue_word(cbr_pkg::FUNC_DISCONNECT, 8'($urandom), 1'($urandom));
        return;
      end
      if (strike && flaw == FLAW_RESTART) begin
        queue_packet(16'h0000, hdr);
        seq = 16'd1;
        pos = 0;
      end
      if (strike && flaw == FLAW_RUNT) begin
        queue_word(cbr_pkg::FUNC_BYTE, 8'($urandom), 1'b1);
      end
      n = $urandom_range(1, chunk_max);
      if (flaw == FLAW_OVERFLOW || n > blob.size() - pos) begin
        n = blob.size() - pos;
      end
      part.delete();
      for (int i = 0; i < n; i++) begin
        part.push_back(blob[pos + i]);
      end
      if (strike && flaw == FLAW_GAP) begin
        do bad_seq = 16'($urandom); while (bad_seq == 16'd0 || bad_seq == seq);
        queue_packet(bad_seq, part);
      end else begin
        queue_packet(seq, part);
      end
      pos += n;
      seq = seq + 16'd1;
    end while (pos < blob.size());

    case ($urandom_range(3))
      0: queue_word(cbr_pkg::FUNC_DISCONNECT, 8'($urandom), 1'($urandom));
      1: begin
        part.delete();
        repeat ($urandom_range(3)) part.push_back(8'($urandom));
        queue_packet(16'($urandom), part);
      end
      default: ;
    endcase
  endtask

  task automatic random_episode();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    len = ($urandom_range(19) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
    if (pick < 60) begin
      send_blob(len, $urandom_range(1, 12), FLAW_NONE);
    end else if (pick < 90) begin
      send_blob(len, $urandom_range(1, 12), flaw_e'($urandom_range(FLAW_CRC, FLAW_RUNT)));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        queue_word(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic random_phase();
    int unsigned mark;
    mark = words_queued;
    while (words_queued - mark < WORDS_PER_PHASE) random_episode();
  endtask

  task automatic write_reg(input logic [cbr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == cbr_pkg::CFG_MAGIC) begin
      magic_cfg = value;
    end else if (idx == cbr_pkg::CFG_VERSION) begin
      version_cfg = value[15:0];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    while (outbound.size() != 0 || in_valid || awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    octets_t one_byte;
    magic_cfg = cbr_pkg::MAGIC_RESET;
    version_cfg = cbr_pkg::VERSION_RESET;
    link_state = cbr_pkg::ST_IDLE;
    clear_blob();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    queue_word(cbr_pkg::FUNC_BYTE, 8'hFF, 1'b1);
    queue_word(FUNC_UNDEFINED, 8'h00, 1'b0);
    queue_word(cbr_pkg::FUNC_DISCONNECT, 8'h00, 1'b0);
    queue_word(cbr_pkg::FUNC_CONNECT, 8'hA5, 1'b1);
    queue_packet(16'h0000, header_body(cbr_pkg::MAGIC_RESET, cbr_pkg::VERSION_RESET,
                                       16'd0, 32'h0));
    queue_packet(16'h0001, one_byte);
    one_byte.push_back(8'hFF);
    queue_packet(16'hFFFF, one_byte);
    queue_word(cbr_pkg::FUNC_DISCONNECT, 8'hFF, 1'b1);
    settle();

    write_reg(cbr_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
    write_reg(cbr_pkg::CFG_VERSION, 32'hFFFF_FFFF);
    random_phase();
    settle();

    send_idle_pct <= 77;
    recv_idle_pct <= 14;
    write_reg(cbr_pkg::CFG_MAGIC, 32'h0);
    write_reg(cbr_pkg::CFG_VERSION, 32'hABCD_0000);
    random_phase();
    settle();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_reg(cbr_pkg::CFG_MAGIC, $urandom);
    write_reg(cbr_pkg::CFG_VERSION, $urandom);
    random_phase();
    @(posedge clk);
    holdoff_go <= 1'b1;
    @(posedge clk);
    holdoff_go <= 1'b0;
    settle();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
